// ===== hw/rtl/planar_body_integrator_macros.svh =====
// Assertion macros used by the integrator checker.
`ifndef PLANAR_BODY_INTEGRATOR_MACROS_SVH
`define PLANAR_BODY_INTEGRATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("integrator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PBI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("integrator assertion failed");

`endif

// ===== hw/rtl/pbi_pkg.sv =====
// Shared types, codes and arithmetic helpers of the planar body integrator.
`default_nettype none
package pbi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DT_SHIFT      = 16;

	typedef enum logic [1:0] {
		CMD_ADD_ACC = 2'd0,
		CMD_SET_VEL = 2'd1,
		CMD_TICK    = 2'd2,
		CMD_SET_POS = 2'd3
	} pbi_cmd_t;

	localparam logic [1:0] CFG_MAX_ACC = 2'd0;
	localparam logic [1:0] CFG_VEL_LOSS = 2'd1;
	localparam logic [1:0] CFG_DECEL = 2'd2;

	// state vector register indexes
	localparam logic [2:0] SEL_POS = 3'd0;
	localparam logic [2:0] SEL_VEL = 3'd2;
	localparam logic [2:0] SEL_ACC = 3'd4;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_LOAD,
		OP_ACC_ADD,
		OP_MUL_DT,
		OP_ADD_DT,
		OP_SQX,
		OP_SQY,
		OP_SUM,
		OP_SQMAX,
		OP_SQRT,
		OP_RATE,
		OP_TGT_MAX,
		OP_TGT_SHR,
		OP_MULT,
		OP_DIV,
		OP_WR,
		OP_OUT
	} pbi_op_t;

	typedef struct packed {
		pbi_op_t    op;
		logic [2:0] sel;
		logic [2:0] dst;
	} pbi_ctl_t;

	typedef struct packed {
		logic gt;
		logic len_zero;
		logic busy;
	} pbi_sts_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		mag32 = v[31] ? (32'd0 - v) : v;
	endfunction

	function automatic logic signed [31:0] with_sign(input logic signed [31:0] r,
			input logic [31:0] m);
		with_sign = r[31] ? (32'd0 - m) : m;
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31])
			sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			sat_add = s[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pbi_datapath.sv =====
// Datapath: state vectors, config registers, multiplier, sqrt and divide units.
`default_nettype none
module pbi_datapath
	import pbi_pkg::*;
#(
	parameter logic [30:0] MAX_ACC_RST = 31'd65536000
) (
	input  wire                clk,
	input  wire                arst_n,
	input  pbi_ctl_t           ctl,
	output pbi_sts_t           sts,
	input  wire signed [31:0]  vec_x,
	input  wire signed [31:0]  vec_y,
	input  wire        [15:0]  delta_time,
	input  wire                cfg_we,
	input  wire        [1:0]   cfg_index,
	input  wire        [30:0]  cfg_data,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] acc_x,
	output logic signed [31:0] acc_y
);

	logic signed [31:0] st_q [6];
	logic signed [31:0] st_nxt [6];
	logic signed [31:0] vx_q, vy_q;
	logic [15:0] dt_q;
	logic [30:0] max_q, loss_q, dec_q;
	logic [63:0] prod_q, sum_q, n_q, dlow_q;
	logic [35:0] rem_q;
	logic [31:0] root_q, drem_q, target_q;
	logic [4:0]  cnt_q;
	logic        busy_q, is_div_q;

	logic signed [31:0] a_val, b_val, d_val;
	logic [35:0] rem_n, trial;
	logic [32:0] dt_n;
	logic [31:0] dshr;

	function automatic logic signed [31:0] pick(input logic [2:0] s,
			input logic signed [31:0] r0, input logic signed [31:0] r1,
			input logic signed [31:0] r2, input logic signed [31:0] r3,
			input logic signed [31:0] r4, input logic signed [31:0] r5);
		case (s)
			3'd0: pick = r0;
			3'd1: pick = r1;
			3'd2: pick = r2;
			3'd3: pick = r3;
			3'd4: pick = r4;
			default: pick = r5;
		endcase
	endfunction

	always_comb begin
		a_val = pick(ctl.sel, st_q[0], st_q[1], st_q[2], st_q[3], st_q[4], st_q[5]);
		b_val = pick(ctl.sel | 3'd1, st_q[0], st_q[1], st_q[2], st_q[3], st_q[4], st_q[5]);
		d_val = pick(ctl.dst, st_q[0], st_q[1], st_q[2], st_q[3], st_q[4], st_q[5]);
		rem_n = {rem_q[33:0], n_q[63:62]};
		trial = {2'b00, root_q, 2'b01};
		dt_n  = {drem_q, dlow_q[31]};
		dshr  = prod_q[47:16];
	end

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			st_nxt[i] = st_q[i];
		end
		case (ctl.op)
			OP_LOAD: begin
				st_nxt[ctl.sel]        = vx_q;
				st_nxt[ctl.sel | 3'd1] = vy_q;
			end
			OP_ACC_ADD: begin
				st_nxt[SEL_ACC]        = sat_add(st_q[SEL_ACC], vx_q);
				st_nxt[SEL_ACC | 3'd1] = sat_add(st_q[SEL_ACC | 3'd1], vy_q);
			end
			OP_ADD_DT: st_nxt[ctl.dst] = sat_add(d_val, with_sign(a_val, dshr));
			OP_WR: st_nxt[ctl.sel] = with_sign(a_val, dlow_q[31:0]);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				st_q[i] <= '0;
			end
			max_q    <= MAX_ACC_RST;
			loss_q   <= '0;
			dec_q    <= '0;
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			is_div_q <= 1'b0;
		end else begin
			for (int i = 0; i < 6; i++) begin
				st_q[i] <= st_nxt[i];
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_ACC:  max_q  <= cfg_data;
					CFG_VEL_LOSS: loss_q <= cfg_data;
					CFG_DECEL:    dec_q  <= cfg_data;
					default: ;
				endcase
			end
			if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0)
					busy_q <= 1'b0;
			end
			case (ctl.op)
				OP_SQRT: begin
					busy_q   <= 1'b1;
					is_div_q <= 1'b0;
					cnt_q    <= 5'd31;
				end
				OP_DIV: begin
					busy_q   <= 1'b1;
					is_div_q <= 1'b1;
					cnt_q    <= 5'd31;
				end
				default: ;
			endcase
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		// one restoring sqrt or divide step per busy cycle
		if (busy_q) begin
			if (is_div_q) begin
				if (dt_n >= {1'b0, root_q}) begin
					drem_q <= 32'(dt_n - {1'b0, root_q});
					dlow_q <= {dlow_q[62:0], 1'b1};
				end else begin
					drem_q <= dt_n[31:0];
					dlow_q <= {dlow_q[62:0], 1'b0};
				end
			end else begin
				n_q <= {n_q[61:0], 2'b00};
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[30:0], 1'b0};
				end
			end
		end
		case (ctl.op)
			OP_LATCH: begin
				vx_q <= vec_x;
				vy_q <= vec_y;
				dt_q <= delta_time;
			end
			OP_MUL_DT: prod_q <= 64'(mag32(a_val)) * 64'(dt_q);
			OP_SQX:    prod_q <= 64'(mag32(a_val)) * 64'(mag32(a_val));
			OP_SQY: begin
				sum_q  <= prod_q;
				prod_q <= 64'(mag32(b_val)) * 64'(mag32(b_val));
			end
			OP_SUM:   sum_q  <= sum_q + prod_q;
			OP_SQMAX: prod_q <= 64'(max_q) * 64'(max_q);
			OP_SQRT: begin
				n_q    <= sum_q;
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_RATE: prod_q <= 64'((ctl.sel == SEL_VEL) ? loss_q : dec_q) * 64'(dt_q);
			OP_TGT_MAX: target_q <= {1'b0, max_q};
			OP_TGT_SHR: target_q <= root_q - ((dshr > root_q) ? root_q : dshr);
			OP_MULT: prod_q <= 64'(mag32(a_val)) * 64'(target_q);
			OP_DIV: begin
				drem_q <= prod_q[63:32];
				dlow_q <= {32'd0, prod_q[31:0]};
			end
			OP_OUT: begin
				pos_x <= st_q[0];
				pos_y <= st_q[1];
				vel_x <= st_q[2];
				vel_y <= st_q[3];
				acc_x <= st_q[4];
				acc_y <= st_q[5];
			end
			default: ;
		endcase
	end

	assign sts.gt       = sum_q > prod_q;
	assign sts.len_zero = root_q == 32'd0;
	assign sts.busy     = busy_q;

endmodule
`default_nettype wire

// ===== hw/rtl/pbi_ctrl.sv =====
// Controller: sequences each command through the shared datapath units.
`default_nettype none
module pbi_ctrl
	import pbi_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [1:0] command,
	output logic       out_valid,
	input  wire        out_ready,
	output pbi_ctl_t   ctl,
	input  pbi_sts_t   sts
);

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_ACC, S_DTM, S_DTA, S_SQX, S_SQY, S_SUM, S_SQMAX,
		S_TEST, S_SQRT, S_SQW, S_RATE, S_TGT, S_MULT, S_DIV, S_DIVW, S_WR, S_FIN
	} state_t;

	state_t     state_q;
	logic [1:0] cmd_q, k_q;
	logic       comp_q, shrink_q, out_valid_q;
	logic [2:0] pair_q, src;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign src       = k_q[1] ? {1'b0, k_q} : {1'b1, k_q};

	always_comb begin
		ctl.op  = OP_NONE;
		ctl.sel = pair_q;
		ctl.dst = src - 3'd2;
		case (state_q)
			S_IDLE:  if (in_valid) ctl.op = OP_LATCH;
			S_LOAD: begin
				ctl.op  = OP_LOAD;
				ctl.sel = (cmd_q == CMD_SET_VEL) ? SEL_VEL : SEL_POS;
			end
			S_ACC:   ctl.op = OP_ACC_ADD;
			S_DTM: begin
				ctl.op  = OP_MUL_DT;
				ctl.sel = src;
			end
			S_DTA: begin
				ctl.op  = OP_ADD_DT;
				ctl.sel = src;
			end
			S_SQX:   ctl.op = OP_SQX;
			S_SQY:   ctl.op = OP_SQY;
			S_SUM:   ctl.op = OP_SUM;
			S_SQMAX: ctl.op = OP_SQMAX;
			S_SQRT:  ctl.op = OP_SQRT;
			S_RATE:  ctl.op = OP_RATE;
			S_TGT:   ctl.op = shrink_q ? OP_TGT_SHR : OP_TGT_MAX;
			S_MULT: begin
				ctl.op  = OP_MULT;
				ctl.sel = pair_q | {2'b00, comp_q};
			end
			S_DIV:   ctl.op = OP_DIV;
			S_WR: begin
				ctl.op  = OP_WR;
				ctl.sel = pair_q | {2'b00, comp_q};
			end
			S_FIN:   if (!out_valid_q || out_ready) ctl.op = OP_OUT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cmd_q       <= CMD_ADD_ACC;
			k_q         <= '0;
			comp_q      <= 1'b0;
			shrink_q    <= 1'b0;
			pair_q      <= SEL_ACC;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= command;
						k_q   <= '0;
						case (command)
							CMD_ADD_ACC: state_q <= S_ACC;
							CMD_TICK:    state_q <= S_DTM;
							default:     state_q <= S_LOAD;
						endcase
					end
				end
				S_LOAD: state_q <= S_FIN;
				S_ACC: begin
					pair_q   <= SEL_ACC;
					shrink_q <= 1'b0;
					state_q  <= S_SQX;
				end
				S_DTM: state_q <= S_DTA;
				S_DTA: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						pair_q   <= SEL_VEL;
						shrink_q <= 1'b1;
						state_q  <= S_SQX;
					end else begin
						state_q <= S_DTM;
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: state_q <= S_SUM;
				S_SUM: state_q <= shrink_q ? S_SQRT : S_SQMAX;
				S_SQMAX: state_q <= S_TEST;
				S_TEST: state_q <= sts.gt ? S_SQRT : S_FIN;
				S_SQRT: state_q <= S_SQW;
				S_SQW: if (!sts.busy) state_q <= shrink_q ? S_RATE : S_TGT;
				S_RATE: state_q <= S_TGT;
				S_TGT: begin
					comp_q <= 1'b0;
					if (!sts.len_zero)
						state_q <= S_MULT;
					else if (shrink_q && pair_q == SEL_VEL) begin
						pair_q  <= SEL_ACC;
						state_q <= S_SQX;
					end else
						state_q <= S_FIN;
				end
				S_MULT: state_q <= S_DIV;
				S_DIV:  state_q <= S_DIVW;
				S_DIVW: if (!sts.busy) state_q <= S_WR;
				S_WR: begin
					if (!comp_q) begin
						comp_q  <= 1'b1;
						state_q <= S_MULT;
					end else if (shrink_q && pair_q == SEL_VEL) begin
						pair_q  <= SEL_ACC;
						state_q <= S_SQX;
					end else
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/planar_body_integrator.sv =====
// Set commands load a vector; add-acceleration runs one square root and two divides when it clamps.
// Tick: two square roots and four divides when both vectors are nonzero, run on one shared
// restoring sqrt/divide unit; a zero vector skips its divides.
// One request is in work at a time; the result register frees the input side.
// Reset (arst_n low): state vectors zero, max_acceleration 1000.0, other config registers zero.
`default_nettype none
module planar_body_integrator
	import pbi_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	// request channel
	input  wire                in_valid,
	output logic               in_ready,
	input  wire        [1:0]   command,
	input  wire signed [31:0]  vec_x,
	input  wire signed [31:0]  vec_y,
	input  wire        [15:0]  delta_time,
	// result channel
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] acc_x,
	output logic signed [31:0] acc_y,
	// register write channel
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire        [1:0]   cfg_index,
	input  wire        [30:0]  cfg_data
);

	// 1000.0 in the chosen format, limited to the 31-bit register range
	localparam longint unsigned MaxAccFull = 64'd1000 << FRAC_BITS;
	localparam logic [30:0] MAX_ACC_RST =
		(MaxAccFull > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : MaxAccFull[30:0];

	pbi_ctl_t ctl;
	pbi_sts_t sts;

	// registers are always writable; the sender must write only with no request in flight, not enforced here
	assign cfg_ready = 1'b1;

	// sequencer: walks each request through the shared units
	pbi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	// state vectors, multiplier, sqrt/divide unit and result register
	pbi_datapath #(
		.MAX_ACC_RST (MAX_ACC_RST)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.vec_x      (vec_x),
		.vec_y      (vec_y),
		.delta_time (delta_time),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.acc_x      (acc_x),
		.acc_y      (acc_y)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/pbi_checker.sv =====
// Port-level checker for the integrator, bound to the top level.
`default_nettype none
`include "planar_body_integrator_macros.svh"
module pbi_checker
	import pbi_pkg::*;
(
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_ready,
	input wire        [1:0]  command,
	input wire signed [31:0] vec_x,
	input wire               out_valid,
	input wire               out_ready,
	input wire signed [31:0] pos_x,
	input wire signed [31:0] vel_x
);

	// one request at a time
	`PBI_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && in_ready, !in_ready)

	// a stalled result holds
	`PBI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(pos_x))

	// set velocity passes through the load and finish states into the result when the output is free
	`PBI_ASSERT_IMPL(a_set_vel, clk, arst_n,
		in_valid && in_ready && command == CMD_SET_VEL && !out_valid,
		##3 (out_valid && vel_x == $past(vec_x, 3)))

endmodule

bind planar_body_integrator pbi_checker u_pbi_checker (.*);
`default_nettype wire
